[hw/rtl/k_palindrome_check_top_macros.svh]
// ----------------------------------------------------------------------------
// k_palindrome_check_top_macros.svh
// Assertion helpers for the k-deletion palindrome checker
// ----------------------------------------------------------------------------
`ifndef K_PALINDROME_CHECK_TOP_MACROS_SVH
`define K_PALINDROME_CHECK_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define KPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kpc_pkg.sv]
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared constants for the k-deletion palindrome checker
// ----------------------------------------------------------------------------
package kpc_pkg;

  // default string buffer depth
  localparam int unsigned KpcMaxLen = 64;

  // configuration port
  localparam int unsigned KpcRemWidth   = 7;
  localparam int unsigned KpcDataWidth  = 32;
  localparam int unsigned KpcAddrWidth  = 3;
  localparam int unsigned KpcSymWidth   = 8;

  // register index taken from paddr[2]
  localparam logic RegMaxRemovals = 1'b0;

endpackage

[hw/rtl/kpc_ram.sv]
// ----------------------------------------------------------------------------
// kpc_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module kpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/k_palindrome_check_top.sv]
// ----------------------------------------------------------------------------
// k_palindrome_check_top
// Checks whether a string becomes a palindrome after at most max_removals
// deletions, using the longest-palindromic-subsequence row recurrence.
// Load: one character per cycle while busy is low.
// After the last transfer of a string, busy stays high while the table is filled
// (one row RAM access per table cell, plus a fetch per row);
// done pulses in the first cycle with busy low again.
// An overflowed string gives its result in the cycle after the last transfer.
// Reset clears the character counter, flags and max_removals; RAM contents are kept.
// ----------------------------------------------------------------------------
`include "k_palindrome_check_top_macros.svh"

module k_palindrome_check_top
  import kpc_pkg::*;
#(
  parameter int unsigned MaxLen = KpcMaxLen
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic [KpcSymWidth-1:0]  symbol_i,
  input  logic                    is_last_i,
  // result
  output logic                    done_o,
  output logic                    verdict_o,
  output logic                    overflow_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [KpcAddrWidth-1:0] paddr,
  input  logic [KpcDataWidth-1:0] pwdata,
  output logic [KpcDataWidth-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned AW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CW   = $clog2(MaxLen + 1);
  localparam int unsigned CMPW = (CW > KpcRemWidth) ? CW : KpcRemWidth;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_START,
    ST_ROW_CI,
    ST_ROW_J,
    ST_FINISH
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   too_long_q, too_long_d;
  logic [CW-1:0]          len_q, len_d;
  logic [AW-1:0]          row_q, row_d;
  logic [AW-1:0]          col_q, col_d;
  logic [KpcSymWidth-1:0] ci_q, ci_d;
  logic [CW-1:0]          left_q, left_d;
  logic [CW-1:0]          diag_q, diag_d;
  logic [KpcRemWidth-1:0] max_rem_q, max_rem_d;
  logic                   done_q, done_d;
  logic                   verdict_q, verdict_d;
  logic                   overflow_q, overflow_d;

  // memory ports
  logic                   chr_we;
  logic [AW-1:0]          chr_waddr;
  logic [AW-1:0]          chr_raddr;
  logic [KpcSymWidth-1:0] chr_rdata;
  logic                   lps_we;
  logic [AW-1:0]          lps_waddr;
  logic [CW-1:0]          lps_wdata;
  logic [AW-1:0]          lps_raddr;
  logic [CW-1:0]          lps_rdata;

  logic                   accept;
  logic                   cfg_write;
  logic [CW-1:0]          row_nxt;
  logic [CW-1:0]          col_nxt;
  logic [CW-1:0]          cell_val;
  logic [CW-1:0]          need;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign row_nxt   = CW'(row_q) + CW'(1);
  assign col_nxt   = CW'(col_q) + CW'(1);
  assign need      = len_q - left_q;

  // one table cell: match extends the inner diagonal, else take the better neighbor
  always_comb begin
    if (ci_q == chr_rdata) begin
      cell_val = diag_q + CW'(2);
    end else if (left_q > lps_rdata) begin
      cell_val = left_q;
    end else begin
      cell_val = lps_rdata;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    too_long_d = too_long_q;
    len_d      = len_q;
    row_d      = row_q;
    col_d      = col_q;
    ci_d       = ci_q;
    left_d     = left_q;
    diag_d     = diag_q;
    max_rem_d  = max_rem_q;
    done_d     = 1'b0;
    verdict_d  = verdict_q;
    overflow_d = overflow_q;

    chr_we    = 1'b0;
    chr_waddr = count_q[AW-1:0];
    chr_raddr = col_q;
    lps_we    = 1'b0;
    lps_waddr = col_q;
    lps_wdata = cell_val;
    lps_raddr = col_q;

    if (cfg_write && (paddr[2] == RegMaxRemovals)) begin
      max_rem_d = pwdata[KpcRemWidth-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CW'(MaxLen)) begin
            chr_we  = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            too_long_d = 1'b1;
          end
          if (is_last_i) begin
            count_d    = '0;
            too_long_d = 1'b0;
            if (too_long_q || (count_q >= CW'(MaxLen))) begin
              done_d     = 1'b1;
              verdict_d  = 1'b0;
              overflow_d = 1'b1;
            end else begin
              len_d   = count_q + CW'(1);
              row_d   = count_q[AW-1:0];
              state_d = ST_ROW_START;
            end
          end
        end
      end
      ST_ROW_START: begin
        // fetch s[i] and seed the diagonal cell
        chr_raddr = row_q;
        lps_we    = 1'b1;
        lps_waddr = row_q;
        lps_wdata = CW'(1);
        left_d    = CW'(1);
        diag_d    = '0;
        state_d   = ST_ROW_CI;
      end
      ST_ROW_CI: begin
        ci_d = chr_rdata;
        if (row_nxt < len_q) begin
          chr_raddr = row_nxt[AW-1:0];
          lps_raddr = row_nxt[AW-1:0];
          col_d     = row_nxt[AW-1:0];
          state_d   = ST_ROW_J;
        end else if (row_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          row_d   = row_q - AW'(1);
          state_d = ST_ROW_START;
        end
      end
      ST_ROW_J: begin
        // read data for col_q is here; write it back and fetch the next column if there is one
        lps_we = 1'b1;
        left_d = cell_val;
        diag_d = lps_rdata;
        if (col_nxt < len_q) begin
          chr_raddr = col_nxt[AW-1:0];
          lps_raddr = col_nxt[AW-1:0];
          col_d     = col_nxt[AW-1:0];
        end else if (row_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          row_d   = row_q - AW'(1);
          state_d = ST_ROW_START;
        end
      end
      ST_FINISH: begin
        done_d     = 1'b1;
        overflow_d = 1'b0;
        verdict_d  = (CMPW'(need) <= CMPW'(max_rem_q));
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      too_long_q <= 1'b0;
      max_rem_q  <= '0;
      done_q     <= 1'b0;
      verdict_q  <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      too_long_q <= too_long_d;
      max_rem_q  <= max_rem_d;
      done_q     <= done_d;
      verdict_q  <= verdict_d;
      overflow_q <= overflow_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    row_q  <= row_d;
    col_q  <= col_d;
    ci_q   <= ci_d;
    left_q <= left_d;
    diag_q <= diag_d;
  end

  kpc_ram #(
    .Width (KpcSymWidth),
    .Depth (MaxLen)
  ) u_chr_ram (
    .clk_i   (clk_i),
    .we_i    (chr_we),
    .waddr_i (chr_waddr),
    .wdata_i (symbol_i),
    .raddr_i (chr_raddr),
    .rdata_o (chr_rdata)
  );

  kpc_ram #(
    .Width (CW),
    .Depth (MaxLen)
  ) u_lps_ram (
    .clk_i   (clk_i),
    .we_i    (lps_we),
    .waddr_i (lps_waddr),
    .wdata_i (lps_wdata),
    .raddr_i (lps_raddr),
    .rdata_o (lps_rdata)
  );

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign verdict_o  = verdict_q;
  assign overflow_o = overflow_q;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == RegMaxRemovals) ?
                      KpcDataWidth'(max_rem_q) : '0;

  `KPC_ASSERT_SAME(a_done_when_idle, done_o, !busy, "result while table fill active")
  `KPC_ASSERT_SAME(a_ovf_no_verdict, done_o && overflow_o, !verdict_o,
                   "overflow result with verdict set")
  `KPC_ASSERT_NEXT(a_no_result_mid_string, accept && !is_last_i, !done_o,
                   "result after a non-final transfer")
  `KPC_ASSERT_SAME(a_col_right_of_row, state_q == ST_ROW_J, col_q > row_q,
                   "column index not right of row index")

endmodule

[tb/sv/k_palindrome_check_top_test.sv]
// ----------------------------------------------------------------------------
// k_palindrome_check_top_test
// Feeds strings one character per transfer into the k-deletion palindrome
// checker and checks every verdict against a subsequence-table predictor.
// max_removals is set over the APB port between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_palindrome_check_top_test;
  import kpc_pkg::*;

  localparam int unsigned MaxLen        = KpcMaxLen;
  localparam int unsigned StallLimit    = 12000;
  localparam int unsigned DrainCycles   = 2200;
  localparam int unsigned ItemsPerPhase = 225;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned SteadyPhase   = 3;

  typedef struct packed {
    logic [KpcSymWidth-1:0] symbol;
    logic                   is_last;
  } char_item_t;

  typedef struct packed {
    logic verdict;
    logic overflow;
  } verdict_t;

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  logic [KpcSymWidth-1:0]  symbol_i  = '0;
  logic                    is_last_i = 1'b0;
  logic                    done_o;
  logic                    verdict_o;
  logic                    overflow_o;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [KpcAddrWidth-1:0] paddr     = '0;
  logic [KpcDataWidth-1:0] pwdata    = '0;
  logic [KpcDataWidth-1:0] prdata;
  logic                    pready;

  // pending characters and verdicts still to come
  char_item_t char_queue[$];
  verdict_t   verdict_queue[$];

  // predictor state
  logic [KpcSymWidth-1:0] sym_store [MaxLen];
  int unsigned            char_total   = 0;
  logic                   too_long     = 1'b0;
  logic [KpcRemWidth-1:0] max_removals = '0;

  int unsigned fail_count   = 0;
  int unsigned stall_cycles = 0;
  logic        steady_feed  = 1'b0;

  k_palindrome_check_top i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .symbol_i,
    .is_last_i,
    .done_o,
    .verdict_o,
    .overflow_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // longest palindromic subsequence over the stored characters
  function automatic int unsigned pal_subseq_len(int unsigned n);
    int unsigned span [MaxLen][MaxLen];
    for (int i = int'(n) - 1; i >= 0; i--) begin
      span[i][i] = 1;
      for (int j = i + 1; j < int'(n); j++) begin
        if (sym_store[i] == sym_store[j]) begin
          span[i][j] = (j == i + 1) ? 2 : span[i+1][j-1] + 2;
        end else begin
          span[i][j] = (span[i+1][j] > span[i][j-1]) ? span[i+1][j] : span[i][j-1];
        end
      end
    end
    return span[0][n-1];
  endfunction

  function automatic void absorb_char(char_item_t item);
    int unsigned deletions;
    if (char_total < MaxLen) begin
      sym_store[char_total] = item.symbol;
      char_total++;
    end else begin
      too_long = 1'b1;
    end
    if (item.is_last) begin
      if (too_long) begin
        verdict_queue.push_back('{verdict: 1'b0, overflow: 1'b1});
      end else begin
        deletions = char_total - pal_subseq_len(char_total);
        verdict_queue.push_back('{verdict: (deletions <= max_removals), overflow: 1'b0});
      end
      char_total = 0;
      too_long   = 1'b0;
    end
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni || char_queue.size() == 0 ||
        (!steady_feed && $urandom_range(0, 99) < 33)) begin
      start    <= 1'b0;
      symbol_i <= KpcSymWidth'($urandom);
    end else begin
      start     <= 1'b1;
      symbol_i  <= char_queue[0].symbol;
      is_last_i <= char_queue[0].is_last;
    end
  end

  // monitor: transfers and results sampled on the rising edge
  always @(posedge clk_i) begin
    char_item_t item;
    verdict_t   want;
    logic       took;
    logic       matched;
    if (rst_ni) begin
      took    = start && !busy;
      matched = 1'b0;
      if (took) begin
        item = char_queue.pop_front();
        absorb_char(item);
      end
      if (done_o) begin
        if (verdict_queue.size() == 0) begin
          $error("result with no verdict pending: verdict %0d overflow %0d",
                 verdict_o, overflow_o);
          fail_count++;
        end else begin
          matched = 1'b1;
          want = verdict_queue.pop_front();
          if (verdict_o !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, verdict_o);
            fail_count++;
          end
          if (overflow_o !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, overflow_o);
            fail_count++;
          end
        end
      end
      // a spurious result does not count as progress
      if (took || matched) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void queue_string(logic [KpcSymWidth-1:0] text[$]);
    foreach (text[i]) begin
      char_queue.push_back('{symbol: text[i], is_last: (i == text.size() - 1)});
    end
  endfunction

  // mostly near-palindromes so the deletion count lands around the limit
  function automatic void queue_random_string(int unsigned len);
    logic [KpcSymWidth-1:0] text[$];
    logic [KpcSymWidth-1:0] base;
    int unsigned            kind;
    int unsigned            spread;
    int unsigned            edits;
    base   = ($urandom_range(0, 1) != 0) ? 8'h61 : KpcSymWidth'($urandom);
    spread = ($urandom_range(0, 2) != 0) ? 3 : 255;
    kind   = $urandom_range(0, 9);
    for (int unsigned i = 0; i < len; i++) begin
      if (kind >= 4 && i >= (len + 1) / 2) begin
        text.push_back(text[len - 1 - i]);
      end else begin
        text.push_back(base + KpcSymWidth'($urandom_range(0, spread)));
      end
    end
    edits = (kind >= 4) ? $urandom_range(0, 3) : 0;
    for (int unsigned e = 0; e < edits; e++) begin
      text[$urandom_range(0, len - 1)] = base + KpcSymWidth'($urandom_range(0, spread));
    end
    queue_string(text);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 12);
    if (roll < 94) return $urandom_range(13, 40);
    if (roll < 97) return $urandom_range(58, MaxLen);
    return $urandom_range(MaxLen + 1, MaxLen + 16);
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i); while (char_queue.size() != 0 || verdict_queue.size() != 0);
  endtask

  task automatic write_max_removals(input logic [KpcRemWidth-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMaxRemovals, 2'b00};
    pwdata  <= KpcDataWidth'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    max_removals = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== KpcDataWidth'(value)) begin
      $error("max_removals readback: expected %0d, actual %0d", value, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [KpcRemWidth-1:0] removal_steps [NumPhases] =
      '{7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd64, 7'd127, 7'd4};
    int unsigned            phase_start;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of max_removals: only exact palindromes pass
    @(posedge clk_i);
    queue_string('{8'h00});
    queue_string('{8'hff});
    queue_string('{8'h61, 8'h61});
    queue_string('{8'h61, 8'h62});
    queue_string('{8'h61, 8'h62, 8'h61});
    queue_string('{8'h00, 8'hff, 8'hff, 8'h00});
    queue_string('{8'hff, 8'h00, 8'h7f, 8'h80, 8'h01});
    queue_string('{8'h55, 8'haa, 8'h55});
    wait_idle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      // idle gap before max_removals is written for the next phase
      repeat (8) @(negedge clk_i);
      if (p == NumPhases - 1) begin
        removal_steps[p] = KpcRemWidth'($urandom_range(0, 127));
      end
      write_max_removals(removal_steps[p]);
      steady_feed = (p == SteadyPhase);
      @(posedge clk_i);
      phase_start = char_queue.size();
      queue_random_string(MaxLen);
      queue_random_string(MaxLen + 1);
      while (char_queue.size() - phase_start < ItemsPerPhase) begin
        queue_random_string(pick_length());
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
